/* design/p2v_pkg.sv */
// Shared constants for the physical-to-virtual reverse map.
`default_nettype none

package p2v_pkg;

	// Default number of address pairs the table holds.
	localparam int TABLE_ENTRIES_DEF = 64;

	// Width of one virtual or physical address.
	localparam int ADDR_W = 32;

	// Command codes.
	localparam logic [1:0] CMD_REMEMBER = 2'd0;
	localparam logic [1:0] CMD_FORGET   = 2'd1;
	localparam logic [1:0] CMD_RECALL   = 2'd2;
	localparam logic [1:0] CMD_NOP      = 2'd3;

endpackage

`default_nettype wire

/* design/p2v_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module p2v_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/phys_to_virt_reverse_map.sv */
// Top level: physical-to-virtual reverse map with a sequential table search.
//
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+----------------------------------
//  command  | cmd, addr_virtual, addr_physical          | taken when start=1 and busy=0
//  result   | recalled_virtual, hit, status             | valid for one cycle while done=1
//
// The single RAM read port walks the stored pairs one entry per cycle, newest
// first. A forget that removes slot s then closes the gap, one entry moved per
// cycle over the same port. A no-op command or an empty table skips the search.
// Reset clears the entry count, sequencer and result registers; the table RAM
// is not cleared, as only read data from slots below the count is ever used.
// The receiver cannot stall: done pulses once per transaction and the result
// must be taken in that cycle.
`default_nettype none

module phys_to_virt_reverse_map #(
	parameter int TABLE_ENTRIES = p2v_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command transaction
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 cmd,
	input  wire logic [p2v_pkg::ADDR_W-1:0] addr_virtual,
	input  wire logic [p2v_pkg::ADDR_W-1:0] addr_physical,
	// result transaction
	output logic                            done,
	output logic      [p2v_pkg::ADDR_W-1:0] recalled_virtual,
	output logic                            hit,
	output logic                            status
);

	localparam int AD = p2v_pkg::ADDR_W;
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	// Count and index registers must hold TABLE_ENTRIES itself.
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int DW = 2 * AD;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_SHIFT
	} state_t;

	state_t          state_q;
	logic [1:0]      cmd_q;
	logic [AD-1:0]   va_q;
	logic [AD-1:0]   pa_q;
	logic [CW-1:0]   count_q;   // valid pairs, slot 0 oldest
	logic [CW-1:0]   idx_q;     // next RAM read index
	logic            more_q;    // scan still has entries to issue
	logic            pend_q;    // a read was issued last cycle
	logic [CW-1:0]   pidx_q;    // index of that pending read
	logic            found_q;
	logic [CW-1:0]   slot_q;
	logic [AD-1:0]   vdata_q;
	logic            done_q;
	logic [AD-1:0]   recalled_q;
	logic            hit_q;
	logic            status_q;

	// RAM ports; each word is {virtual, physical}.
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [DW-1:0]   ram_wdata;
	logic [DW-1:0]   ram_rdata;
	logic [AW-1:0]   ram_raddr;

	logic [AD-1:0]   rd_virt;
	logic [AD-1:0]   rd_phys;
	logic            key_match;
	logic            full;
	logic            shift_issue;
	logic [CW-1:0]   pidx_m1;

	assign rd_virt   = ram_rdata[DW-1:AD];
	assign rd_phys   = ram_rdata[AD-1:0];
	// forget searches by virtual address, the others by physical
	assign key_match = (cmd_q == p2v_pkg::CMD_FORGET) ? (rd_virt == va_q) : (rd_phys == pa_q);
	assign full        = (count_q == CW'(TABLE_ENTRIES));
	assign shift_issue = (idx_q < count_q);
	assign pidx_m1     = pidx_q - CW'(1);

	assign ram_raddr = idx_q[AW-1:0];

	// Write port: new or updated pair at the end of a remember, gap closing during forget.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q[AW-1:0];
		ram_wdata = {va_q, pa_q};
		case (state_q)
			S_FINISH: begin
				if (cmd_q == p2v_pkg::CMD_REMEMBER) begin
					if (found_q) begin
						ram_we = 1'b1;
					end else if (!full) begin
						ram_we    = 1'b1;
						ram_waddr = count_q[AW-1:0];
					end
				end
			end
			S_SHIFT: begin
				ram_we    = pend_q;
				ram_waddr = pidx_m1[AW-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	p2v_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			more_q     <= 1'b0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			cmd_q      <= p2v_pkg::CMD_NOP;
			idx_q      <= '0;
			pidx_q     <= '0;
			slot_q     <= '0;
			recalled_q <= '0;
			hit_q      <= 1'b0;
			status_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						va_q    <= addr_virtual;
						pa_q    <= addr_physical;
						found_q <= 1'b0;
						pend_q  <= 1'b0;
						if (count_q != '0 && cmd != p2v_pkg::CMD_NOP) begin
							// walk from the newest entry down
							idx_q   <= count_q - CW'(1);
							more_q  <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					// one read issued per cycle; compare the one that came back
					pend_q <= more_q;
					pidx_q <= idx_q;
					if (more_q) begin
						if (idx_q == '0) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q - CW'(1);
						end
					end
					if (pend_q) begin
						if (key_match) begin
							found_q <= 1'b1;
							slot_q  <= pidx_q;
							vdata_q <= rd_virt;
							state_q <= S_FINISH;
						end else if (pidx_q == '0) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (cmd_q == p2v_pkg::CMD_FORGET && found_q) begin
						// close the gap: entries above the slot move down one
						idx_q   <= slot_q + CW'(1);
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						done_q     <= 1'b1;
						hit_q      <= found_q;
						recalled_q <= (cmd_q == p2v_pkg::CMD_RECALL && found_q) ? vdata_q : '0;
						status_q   <= (cmd_q == p2v_pkg::CMD_REMEMBER) && !found_q && full;
						if (cmd_q == p2v_pkg::CMD_REMEMBER && !found_q && !full) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					pend_q <= shift_issue;
					pidx_q <= idx_q;
					if (shift_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (!shift_issue && !pend_q) begin
						count_q    <= count_q - CW'(1);
						done_q     <= 1'b1;
						hit_q      <= 1'b1;
						recalled_q <= '0;
						status_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign recalled_virtual = recalled_q;
	assign hit              = hit_q;
	assign status           = status_q;

	// The table never holds more pairs than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count above table size");

	// A result is only produced by a transaction in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command");

	// An accepted command always keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but block not busy");

	// A dropped remember never reports a match.
	a_status_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !hit)
		else $error("table full reported together with a hit");

	// The pair count moves by at most one per transaction, only when done.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(count_q) || $past(state_q) == S_FINISH || $past(state_q) == S_SHIFT)
		else $error("entry count changed outside a completing command");

endmodule

`default_nettype wire
